FILE: design/peak_meter_bar_length_macros.svh
// assertion shorthands for the level meter checker
// both sample on clk and stay quiet while arst_n is low
`ifndef PEAK_METER_BAR_LENGTH_MACROS_SVH
`define PEAK_METER_BAR_LENGTH_MACROS_SVH

// consequent must hold in the same cycle
`define PMBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the next cycle
`define PMBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/pmbl_pkg.sv
`default_nettype none

package pmbl_pkg;

	// field widths
	localparam int STEP_BITS   = 10;
	localparam int LENGTH_BITS = 12;
	localparam int LEVEL_BITS  = 16;
	localparam int RAW_BITS    = 12;
	localparam int DECAY_BITS  = 17;
	localparam int KIND_BITS   = 2;
	localparam int DIR_BITS    = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 17;

	// shared multiplier operands: decay factor / steps / logical step on a,
	// peak / level / pixel lines on b
	localparam int MUL_A_BITS = DECAY_BITS;
	localparam int MUL_B_BITS = LEVEL_BITS;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	// fixed point
	localparam int DECAY_FRAC = 16;
	localparam int FRAC_SHIFT = 15;
	localparam int CONV_BITS  = PROD_BITS - FRAC_SHIFT;
	localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_SHIFT - 1);

	// raw step compare width (magnitude of step_in against steps)
	localparam int RAW_CMP_BITS = (RAW_BITS - 1 > STEP_BITS) ? RAW_BITS - 1 : STEP_BITS;

	// divider: pixel_lines * logical over steps
	localparam int DIVIDEND_BITS = LENGTH_BITS + STEP_BITS;

	// reset values
	localparam logic [STEP_BITS-1:0]  STEPS_RST = STEP_BITS'(100);
	localparam logic [DECAY_BITS-1:0] DECAY_RST = DECAY_BITS'(62259);
	localparam logic [LEVEL_BITS-1:0] PEAK_RST  = LEVEL_BITS'(32768);

	// request kinds
	localparam logic [KIND_BITS-1:0] KIND_DECAY  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DIRECT = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_RAW    = 2'd2;

	// growth directions
	localparam logic [DIR_BITS-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS         = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_START = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_END   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_MUL     = 3'd5;

endpackage

`default_nettype wire

FILE: design/pmbl_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
// the dividend is known to be below divisor * 2^LENGTH_BITS, so the upper
// bits preload the remainder and only LENGTH_BITS steps are needed
module pmbl_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [pmbl_pkg::DIVIDEND_BITS-1:0] dividend,
	input  wire logic [pmbl_pkg::STEP_BITS-1:0]     divisor,
	output logic                                    done,
	output logic [pmbl_pkg::LENGTH_BITS-1:0]        quotient
);
	import pmbl_pkg::*;

	localparam int CNT_BITS = $clog2(LENGTH_BITS + 1);

	logic [CNT_BITS-1:0]    cnt_q;
	logic                   done_q;
	logic [STEP_BITS-1:0]   rem_q;
	logic [LENGTH_BITS-1:0] quot_q;
	logic [STEP_BITS:0]     trial;
	logic [STEP_BITS:0]     diff;
	logic                   fits;

	// trial subtract
	always_comb begin
		trial = {rem_q, quot_q[LENGTH_BITS-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(LENGTH_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[DIVIDEND_BITS-1:LENGTH_BITS];
			quot_q <= dividend[LENGTH_BITS-1:0];
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
			quot_q <= {quot_q[LENGTH_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

FILE: design/peak_meter_bar_length.sv
// Peak-hold level meter driver.
// Input channel (in_valid/in_ready) carries kind, level and step_in. kind 0
// decays the held peak and raises it to level, kind 1 converts level
// directly, kind 2 takes step_in as a raw step. kind 3 is taken and dropped.
// Output channel (out_valid/out_ready) returns step_value, bar_length and
// changed, one result per request of kind 0 to 2.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; a defined register write makes the shown step stale, but a result
// load in that cycle wins. One request is worked at a time by a sequencer
// around one 17x16 multiplier and a one-bit-per-cycle divider; an empty or
// full bar skips the divider. in_ready is high only in the idle state and
// returns together with out_valid as the result is loaded, so no new request
// is taken while one is worked.
// A result waiting on a stalled receiver is held in the output register;
// the next finished result waits in its last state until that one is taken.
// Reset restores the register defaults, a held peak of 1.0, no shown step.
`default_nettype none

module peak_meter_bar_length (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [pmbl_pkg::KIND_BITS-1:0]     kind,
	input  wire logic [pmbl_pkg::LEVEL_BITS-1:0]    level,
	input  wire logic signed [pmbl_pkg::RAW_BITS-1:0] step_in,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [pmbl_pkg::STEP_BITS-1:0]          step_value,
	output logic [pmbl_pkg::LENGTH_BITS-1:0]        bar_length,
	output logic                                    changed,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pmbl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [pmbl_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import pmbl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MDEC,
		S_DEC,
		S_MCONV,
		S_CONV,
		S_BAR,
		S_DIVGO,
		S_DIVW,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [STEP_BITS-1:0]   steps_q;
	logic [DIR_BITS-1:0]    direction_q;
	logic [LENGTH_BITS-1:0] full_length_q;
	logic [LENGTH_BITS-1:0] spacing_start_q;
	logic [LENGTH_BITS-1:0] spacing_end_q;
	logic [DECAY_BITS-1:0]  decay_mul_q;

	// meter state
	logic [LEVEL_BITS-1:0]  peak_q;
	logic [STEP_BITS-1:0]   shown_q;
	logic                   shown_valid_q;

	// working registers
	logic [LEVEL_BITS-1:0]  level_q;
	logic [LEVEL_BITS-1:0]  val_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [LENGTH_BITS-1:0] bar_q;
	logic                   bar_fix_q;

	// output register
	logic                   out_valid_q;
	logic [STEP_BITS-1:0]   step_value_q;
	logic [LENGTH_BITS-1:0] bar_length_q;
	logic                   changed_q;

	logic [STEP_BITS-1:0]    n_eff;
	logic                    in_take;
	logic                    cfg_hit;
	logic [RAW_CMP_BITS-1:0] raw_c;
	logic [STEP_BITS-1:0]    raw_step;
	logic [MUL_A_BITS-1:0]   mul_a;
	logic [MUL_B_BITS-1:0]   mul_b;
	logic [PROD_BITS-1:0]    mul_p;
	logic                    mul_en;
	logic [PROD_BITS-DECAY_FRAC-1:0] decayed;
	logic [LEVEL_BITS-1:0]   decayed_sat;
	logic [LEVEL_BITS-1:0]   peak_new;
	logic [PROD_BITS-1:0]    rounded;
	logic [CONV_BITS-1:0]    conv;
	logic [STEP_BITS-1:0]    conv_step;
	logic [LENGTH_BITS:0]    spacing_sum;
	logic [LENGTH_BITS:0]    lines_diff;
	logic [LENGTH_BITS-1:0]  lines;
	logic                    grow_back;
	logic [STEP_BITS-1:0]    logical;
	logic [LENGTH_BITS-1:0]  offset;
	logic                    div_start;
	logic                    div_done;
	logic [LENGTH_BITS-1:0]  div_quot;
	logic [LENGTH_BITS:0]    len_sum;
	logic [LENGTH_BITS-1:0]  len_final;
	logic                    out_free;
	logic                    out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign cfg_hit   = cfg_valid && (cfg_index <= REG_DECAY_MUL);
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == S_OUT) && out_free;

	// a zero step count acts as one
	assign n_eff = (steps_q == '0) ? STEP_BITS'(1) : steps_q;

	// raw step clamp, negative goes to zero
	always_comb begin
		raw_c    = RAW_CMP_BITS'(step_in[RAW_BITS-2:0]);
		raw_step = (raw_c > RAW_CMP_BITS'(n_eff)) ? n_eff : STEP_BITS'(raw_c);
		if (step_in[RAW_BITS-1]) begin
			raw_step = '0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		case (state_q)
			S_MDEC: begin
				mul_a  = decay_mul_q;
				mul_b  = peak_q;
				mul_en = 1'b1;
			end
			S_MCONV: begin
				mul_a  = MUL_A_BITS'(n_eff);
				mul_b  = val_q;
				mul_en = 1'b1;
			end
			S_BAR: begin
				mul_a  = MUL_A_BITS'(logical);
				mul_b  = MUL_B_BITS'(lines);
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// decayed peak, saturated, then raised to the new level
	always_comb begin
		decayed     = prod_q[PROD_BITS-1:DECAY_FRAC];
		decayed_sat = decayed[LEVEL_BITS] ? '1 : decayed[LEVEL_BITS-1:0];
		peak_new    = (level_q > decayed_sat) ? level_q : decayed_sat;
	end

	// level to step, round to nearest and clamp
	always_comb begin
		rounded   = prod_q + ROUND_HALF;
		conv      = rounded[PROD_BITS-1:FRAC_SHIFT];
		conv_step = (conv > CONV_BITS'(n_eff)) ? n_eff : conv[STEP_BITS-1:0];
	end

	// bar geometry
	always_comb begin
		spacing_sum = {1'b0, spacing_start_q} + {1'b0, spacing_end_q};
		lines_diff  = {1'b0, full_length_q} - spacing_sum;
		lines       = ({1'b0, full_length_q} > spacing_sum) ? lines_diff[LENGTH_BITS-1:0] : '0;
		grow_back   = (direction_q == DIR_UP) || (direction_q == DIR_LEFT);
		logical     = grow_back ? (n_eff - step_q) : step_q;
		offset      = grow_back ? spacing_end_q : spacing_start_q;
	end

	// final length, saturated to the field range
	always_comb begin
		len_sum   = {1'b0, div_quot} + {1'b0, bar_q};
		len_final = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
		if (bar_fix_q) begin
			len_final = bar_q;
		end
	end

	assign div_start = (state_q == S_DIVGO);

	pmbl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIVIDEND_BITS-1:0]),
		.divisor  (n_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q         <= STEPS_RST;
			direction_q     <= DIR_UP;
			full_length_q   <= '0;
			spacing_start_q <= '0;
			spacing_end_q   <= '0;
			decay_mul_q     <= DECAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEPS:         steps_q         <= cfg_data[STEP_BITS-1:0];
				REG_DIRECTION:     direction_q     <= cfg_data[DIR_BITS-1:0];
				REG_FULL_LENGTH:   full_length_q   <= cfg_data[LENGTH_BITS-1:0];
				REG_SPACING_START: spacing_start_q <= cfg_data[LENGTH_BITS-1:0];
				REG_SPACING_END:   spacing_end_q   <= cfg_data[LENGTH_BITS-1:0];
				REG_DECAY_MUL:     decay_mul_q     <= cfg_data[DECAY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, meter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			peak_q        <= PEAK_RST;
			shown_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
			step_value_q  <= '0;
			bar_length_q  <= '0;
			changed_q     <= 1'b0;
		end else begin
			// result valid, set on load and cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// shown step becomes valid on load, stale on a register write
			if (out_load) begin
				shown_valid_q <= 1'b1;
			end else if (cfg_hit) begin
				shown_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						case (kind)
							KIND_DECAY:  state_q <= S_MDEC;
							KIND_DIRECT: state_q <= S_MCONV;
							KIND_RAW:    state_q <= S_BAR;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_MDEC: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					peak_q  <= peak_new;
					state_q <= S_MCONV;
				end
				S_MCONV: begin
					state_q <= S_CONV;
				end
				S_CONV: begin
					state_q <= S_BAR;
				end
				S_BAR: begin
					if ((logical == '0) || (logical == n_eff)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						step_value_q  <= step_q;
						bar_length_q  <= len_final;
						changed_q     <= !shown_valid_q || (step_q != shown_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working data path registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			level_q <= level;
			val_q   <= level;
			step_q  <= raw_step;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		if (state_q == S_DEC) begin
			val_q <= peak_new;
		end
		if (state_q == S_CONV) begin
			step_q <= conv_step;
		end
		if (state_q == S_BAR) begin
			bar_fix_q <= (logical == '0) || (logical == n_eff);
			if (logical == '0) begin
				bar_q <= '0;
			end else if (logical == n_eff) begin
				bar_q <= full_length_q;
			end else begin
				bar_q <= offset;
			end
		end
		if (out_load) begin
			shown_q <= step_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_value = step_value_q;
	assign bar_length = bar_length_q;
	assign changed    = changed_q;

endmodule

`default_nettype wire

FILE: design/peak_meter_bar_length_chk.sv
`default_nettype none

`include "peak_meter_bar_length_macros.svh"

// port-level checks for the level meter
module peak_meter_bar_length_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic [pmbl_pkg::KIND_BITS-1:0]     kind,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [pmbl_pkg::STEP_BITS-1:0]     step_value,
	input wire logic [pmbl_pkg::LENGTH_BITS-1:0]   bar_length,
	input wire logic                               changed
);
	import pmbl_pkg::*;

	// stalled result holds
	`PMBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(step_value) && $stable(bar_length) && $stable(changed), "result changed under stall")

	// a working request blocks the input for at least the next cycle
	`PMBL_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready && (kind == KIND_DECAY || kind == KIND_DIRECT || kind == KIND_RAW), !in_ready, "input not blocked after request")

	// a new result only appears at the end of a busy period
	`PMBL_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without prior work")

endmodule

bind peak_meter_bar_length peak_meter_bar_length_chk u_chk (.*);

`default_nettype wire
